// ===== hdl/sorted_timeout_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_timeout_queue_top_macros.svh
// Assertion macros shared by the checker of the sorted timeout queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMEOUT_QUEUE_TOP_MACROS_SVH
`define SORTED_TIMEOUT_QUEUE_TOP_MACROS_SVH

// Property checked on the rising clock edge, switched off during reset
`define STQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included
`define STQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Types, codes and default sizes for the sorted timeout queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    // Default sizes
    localparam int MAX_TASKS_DEF = 16;
    localparam int TICK_BITS_DEF = 32;

    // Fixed field widths
    localparam int TID_W    = 4;
    localparam int TICK_IN_W = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } stq_state_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic             cmp;     // register compare flags
        logic             add_en;  // insert the item
        logic             rem_en;  // delete the matching entry
        logic [TID_W-1:0] id;
    } stq_op_t;

endpackage

// ===== hdl/sorted_timeout_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_timeout_queue_top
// Wrap-safe sorted timer queue built as a row of slot cells.
//
//   channel | handshake         | fields
//   --------+-------------------+------------------------------------
//   request | start, busy       | req_type, task_id, tick_value
//   result  | done (one cycle)  | status, result_valid, result_task
//
// Each item passes through S_CMP, where the cells register their compare
// flags, then S_EXEC, where the row inserts or shifts in one step; then
// done pulses. busy is high in S_CMP and S_EXEC; a new item may start
// in the cycle in which done pulses.
// Reset empties the queue at once; done cannot be held off.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_top
    import stq_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [TID_W-1:0]     task_id,
    input  logic [TICK_IN_W-1:0] tick_value,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic                 result_valid,
    output logic [TID_W-1:0]     result_task
);

    stq_state_t            state_reg, state_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [TID_W-1:0]      id_reg, id_next;
    logic [TICK_BITS-1:0]  tick_reg, tick_next;
    logic                  done_reg, done_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  rvalid_reg, rvalid_next;
    logic [TID_W-1:0]      rtask_reg, rtask_next;

    stq_op_t               op;
    logic                  del_start;
    logic                  any_match;
    logic                  head_due;
    logic                  full;

    // Row of slots, padded with an empty slot at each end
    logic                  pad_valid [MAX_TASKS+2];
    logic [TID_W-1:0]      pad_tid   [MAX_TASKS+2];
    logic [TICK_BITS-1:0]  pad_wake  [MAX_TASKS+2];
    logic [MAX_TASKS:0]    ins_chain;
    logic [MAX_TASKS:0]    del_chain;
    logic [MAX_TASKS-1:0]  cell_match;
    logic [MAX_TASKS-1:0]  cell_later;

    assign pad_valid[0]           = 1'b0;
    assign pad_tid[0]             = '0;
    assign pad_wake[0]            = '0;
    assign pad_valid[MAX_TASKS+1] = 1'b0;
    assign pad_tid[MAX_TASKS+1]   = '0;
    assign pad_wake[MAX_TASKS+1]  = '0;
    assign ins_chain[0]           = 1'b0;
    assign del_chain[0]           = del_start;

    // Build the row of cells
    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        stq_cell #(
            .TICK_BITS (TICK_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .tick        (tick_reg),
            .left_valid  (pad_valid[i]),
            .left_tid    (pad_tid[i]),
            .left_wake   (pad_wake[i]),
            .right_valid (pad_valid[i+2]),
            .right_tid   (pad_tid[i+2]),
            .right_wake  (pad_wake[i+2]),
            .ins_in      (ins_chain[i]),
            .del_in      (del_chain[i]),
            .ins_out     (ins_chain[i+1]),
            .del_out     (del_chain[i+1]),
            .valid       (pad_valid[i+1]),
            .tid         (pad_tid[i+1]),
            .wake        (pad_wake[i+1]),
            .match       (cell_match[i]),
            .later       (cell_later[i])
        );
    end

    // Summarise the row
    assign any_match = |cell_match;
    assign head_due  = pad_valid[1] & ~cell_later[0];
    assign full      = pad_valid[MAX_TASKS];

    // Sequence one item and decide its outcome
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        id_next     = id_reg;
        tick_next   = tick_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rvalid_next = rvalid_reg;
        rtask_next  = rtask_reg;
        op          = '{cmp: 1'b0, add_en: 1'b0, rem_en: 1'b0, id: id_reg};
        del_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_type;
                    id_next    = task_id;
                    tick_next  = TICK_BITS'(tick_value);
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                op.cmp     = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                rvalid_next = 1'b0;
                rtask_next  = '0;
                priority if (req_reg == REQ_ADD)
                begin
                    priority if (any_match)
                        status_next = ST_DUPLICATE;
                    else if (full)
                        status_next = ST_FULL;
                    else
                        op.add_en = 1'b1;
                end
                else if (req_reg == REQ_REMOVE)
                begin
                    if (any_match)
                        op.rem_en = 1'b1;
                    else
                        status_next = ST_NOT_FOUND;
                end
                else if (req_reg == REQ_POP)
                begin
                    if (head_due)
                    begin
                        del_start   = 1'b1;
                        rvalid_next = 1'b1;
                        rtask_next  = pad_tid[1];
                    end
                end
                else
                begin
                    // Unused request code: leave the queue as it is
                    op.add_en = 1'b0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Hold request and result payload
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        id_reg     <= id_next;
        tick_reg   <= tick_next;
        status_reg <= status_next;
        rvalid_reg <= rvalid_next;
        rtask_reg  <= rtask_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign result_valid = rvalid_reg;
    assign result_task  = rtask_reg;

endmodule

// ===== hdl/stq_cell.sv =====
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted queue: holds an entry, compares it with the
// request and shifts towards either neighbour on insert or delete.
// ----------------------------------------------------------------------------
module stq_cell
    import stq_pkg::*;
#(
    parameter int TICK_BITS = TICK_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stq_op_t              op,
    input  logic [TICK_BITS-1:0] tick,
    input  logic                 left_valid,
    input  logic [TID_W-1:0]     left_tid,
    input  logic [TICK_BITS-1:0] left_wake,
    input  logic                 right_valid,
    input  logic [TID_W-1:0]     right_tid,
    input  logic [TICK_BITS-1:0] right_wake,
    input  logic                 ins_in,
    input  logic                 del_in,
    output logic                 ins_out,
    output logic                 del_out,
    output logic                 valid,
    output logic [TID_W-1:0]     tid,
    output logic [TICK_BITS-1:0] wake,
    output logic                 match,
    output logic                 later
);

    logic                 valid_reg, valid_next;
    logic [TID_W-1:0]     tid_reg, tid_next;
    logic [TICK_BITS-1:0] wake_reg, wake_next;
    logic                 match_reg, match_next;
    logic                 later_reg, later_next;
    logic                 ins_here;
    logic                 del_here;

    // a comes strictly before b when the wrapped difference is negative
    function automatic logic tick_before(input logic [TICK_BITS-1:0] a,
                                         input logic [TICK_BITS-1:0] b);
        logic [TICK_BITS-1:0] diff;
        diff = a - b;
        return diff[TICK_BITS-1];
    endfunction

    // Insert and delete positions ripple along the row
    assign ins_here = op.add_en & (later_reg | ~valid_reg);
    assign ins_out  = ins_in | ins_here;
    assign del_here = del_in | (op.rem_en & match_reg);
    assign del_out  = del_here;

    // Compare flags and slot contents
    always_comb
    begin
        match_next = match_reg;
        later_next = later_reg;
        if (op.cmp)
        begin
            match_next = valid_reg && (tid_reg == op.id);
            later_next = valid_reg && tick_before(tick, wake_reg);
        end
        priority if (ins_in)
        begin
            valid_next = left_valid;
            tid_next   = left_tid;
            wake_next  = left_wake;
        end
        else if (ins_here)
        begin
            valid_next = 1'b1;
            tid_next   = op.id;
            wake_next  = tick;
        end
        else if (del_here)
        begin
            valid_next = right_valid;
            tid_next   = right_tid;
            wake_next  = right_wake;
        end
        else
        begin
            // Hold the entry
            valid_next = valid_reg;
            tid_next   = tid_reg;
            wake_next  = wake_reg;
        end
    end

    // Hold control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            later_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
            later_reg <= later_next;
        end
    end

    // Hold entry payload
    always_ff @(posedge clk)
    begin
        tid_reg  <= tid_next;
        wake_reg <= wake_next;
    end

    assign valid = valid_reg;
    assign tid   = tid_reg;
    assign wake  = wake_reg;
    assign match = match_reg;
    assign later = later_reg;

endmodule

// ===== hdl/stq_checker.sv =====
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks on request and result timing of the sorted queue.
// ----------------------------------------------------------------------------
`include "sorted_timeout_queue_top_macros.svh"

module stq_checker
    import stq_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [STATUS_W-1:0]  status,
    input logic                 result_valid
);

    // Every accepted item gives its result once compare and execute have passed
    `STQ_ASSERT(a_result_follows, (start && !busy) |-> ##3 done, "item result missing")

    // No result without an earlier accepted item
    `STQ_ASSERT(a_no_spurious, done |-> $past(start && !busy, 3), "result without item")

    // A popped task always reports success
    `STQ_ASSERT(a_pop_ok, (done && result_valid) |-> (status == ST_OK), "pop with bad status")

    // Done stays low throughout reset
    `STQ_ASSERT_ALWAYS(a_no_done_in_reset, !rst_n |-> !done, "done during reset")

endmodule

bind sorted_timeout_queue_top stq_checker u_stq_checker (.*);
